FILE: src/sls_pkg.sv
// Shared types and constants for the sprite line search block.
// Used by sls_ctrl, sls_datapath and sprite_line_search_core; depends on nothing.
package sls_pkg;

  // Store geometry.
  localparam int STORE_BYTES  = 160;
  localparam int MAX_PER_LINE = 10;
  localparam int ENTRY_BYTES  = 4;
  localparam int NUM_ENTRIES  = STORE_BYTES / ENTRY_BYTES;
  localparam int IDX_W        = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SA_W         = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CNT_W        = $clog2(MAX_PER_LINE + 1);

  // Fixed field values.
  localparam logic [7:0] LOCKED_BYTE   = 8'hFF;
  localparam logic [7:0] SPRITE_Y_BIAS = 8'd16;
  localparam logic [8:0] HEIGHT_SHORT  = 9'd8;
  localparam logic [8:0] HEIGHT_TALL   = 9'd16;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  // Display modes that leave the store open.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LCD_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_SPRITES_ENABLE = 2'd1;
  localparam logic [1:0] CFG_TALL_SPRITES   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] oam_addr;
    logic [7:0] write_data;
    logic [1:0] lcd_mode;
    logic [7:0] scan_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] sprite_x;
    logic [7:0] sprite_offset;
    logic       found;
    logic       last;
  } out_item_t;

  // Source of the next output beat.
  typedef enum logic [1:0] {
    OUT_NONE_LAST,
    OUT_CPU_READ,
    OUT_PEND_MID,
    OUT_PEND_LAST
  } out_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             mem_wr;
    logic             rd_cpu;
    logic             rd_entry;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] chk_idx;
    logic             scan_start;
    logic             pend_take;
    logic             out_load;
    out_sel_e         out_sel;
  } sls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic scan_en;
    logic hit;
    logic last_hit;
    logic pend_valid;
  } sls_status_t;

endpackage

FILE: src/sls_datapath.sv
// Datapath of the sprite line search: attribute store, config registers,
// entry compare, pending match and output register. Depends on sls_pkg.
module sls_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic                cfg_data_i,
  input  sls_pkg::in_item_t   in_data_i,
  input  sls_pkg::sls_cmd_t   cmd_i,
  output sls_pkg::sls_status_t status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output sls_pkg::out_item_t  out_data_o
);
  import sls_pkg::*;

  logic             lcd_q, spr_q, tall_q;
  logic [7:0]       store_mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] stored_q;
  logic [7:0]       rd_a_q, rd_b_q;
  logic             rd_a_vld_q, rd_b_vld_q;
  logic             rd_ok_q;
  logic [7:0]       line_q;
  logic             scan_tall_q;
  logic             pend_valid_q;
  logic [7:0]       pend_x_q, pend_off_q;
  logic [CNT_W-1:0] count_q;
  logic             out_valid_q;
  out_item_t        out_q, out_d;

  logic             access_open, in_range, wr_en, rd_en;
  logic [SA_W-1:0]  cpu_addr, addr_a, addr_b;
  logic [7:0]       byte0, byte1, ytop;
  logic [8:0]       height, ybot;
  logic             hit;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_q  <= 1'b0;
      spr_q  <= 1'b0;
      tall_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LCD_ENABLE:     lcd_q  <= cfg_data_i;
        CFG_SPRITES_ENABLE: spr_q  <= cfg_data_i;
        CFG_TALL_SPRITES:   tall_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // CPU access gating.
  assign access_open = !lcd_q || (in_data_i.lcd_mode == MODE_HBLANK) ||
                       (in_data_i.lcd_mode == MODE_VBLANK);
  assign in_range    = {1'b0, in_data_i.oam_addr} < 9'(STORE_BYTES);
  assign cpu_addr    = in_data_i.oam_addr[SA_W-1:0];
  assign wr_en       = cmd_i.mem_wr && access_open && in_range;

  // Port A serves CPU reads and byte 0 of an entry, port B byte 1.
  assign addr_a = cmd_i.rd_cpu ? cpu_addr : SA_W'({cmd_i.rd_idx, 2'b00});
  assign addr_b = SA_W'({cmd_i.rd_idx, 2'b01});
  assign rd_en  = cmd_i.rd_cpu || cmd_i.rd_entry;

  // Store array; entries never written read as zero through stored_q.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[cpu_addr] <= in_data_i.write_data;
    end
    if (rd_en) begin
      rd_a_q <= store_mem[addr_a];
      rd_b_q <= store_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q   <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        stored_q[cpu_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_a_vld_q <= stored_q[addr_a];
        rd_b_vld_q <= stored_q[addr_b];
      end
    end
  end

  assign byte0 = rd_a_vld_q ? rd_a_q : 8'd0;
  assign byte1 = rd_b_vld_q ? rd_b_q : 8'd0;

  // Per-item context latched at accept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_ok_q     <= access_open && in_range;
      line_q      <= in_data_i.scan_line;
      scan_tall_q <= tall_q;
    end
  end

  // Vertical range test of the entry under check; the upper sum does not wrap.
  assign ytop   = byte0 - SPRITE_Y_BIAS;
  assign height = scan_tall_q ? HEIGHT_TALL : HEIGHT_SHORT;
  assign ybot   = {1'b0, ytop} + height;
  assign hit    = (line_q >= ytop) && ({1'b0, line_q} < ybot);

  // Pending match and match count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      count_q      <= '0;
    end else if (cmd_i.scan_start) begin
      pend_valid_q <= 1'b0;
      count_q      <= '0;
    end else if (cmd_i.pend_take) begin
      pend_valid_q <= 1'b1;
      count_q      <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_take) begin
      pend_x_q   <= byte1;
      pend_off_q <= 8'({cmd_i.chk_idx, 2'b00});
    end
  end

  // Output beat selection.
  always_comb begin
    out_d = '0;
    unique case (cmd_i.out_sel)
      OUT_NONE_LAST: out_d.last = 1'b1;
      OUT_CPU_READ: begin
        out_d.read_data = rd_ok_q ? byte0 : LOCKED_BYTE;
        out_d.last      = 1'b1;
      end
      OUT_PEND_MID: begin
        out_d.sprite_x      = pend_x_q;
        out_d.sprite_offset = pend_off_q;
        out_d.found         = 1'b1;
      end
      OUT_PEND_LAST: begin
        out_d.sprite_x      = pend_x_q;
        out_d.sprite_offset = pend_off_q;
        out_d.found         = 1'b1;
        out_d.last          = 1'b1;
      end
      default: out_d = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status back to the controller.
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.scan_en    = lcd_q && spr_q;
  assign status_o.hit        = hit;
  assign status_o.last_hit   = hit && (count_q == CNT_W'(MAX_PER_LINE - 1));
  assign status_o.pend_valid = pend_valid_q;

endmodule

FILE: src/sls_ctrl.sv
// Controller of the sprite line search: accepts beats and sequences CPU
// accesses and the entry walk. Depends on sls_pkg.
module sls_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           op_i,
  output logic                 in_stall_o,
  input  sls_pkg::sls_status_t status_i,
  output sls_pkg::sls_cmd_t    cmd_o
);
  import sls_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic             accept, emit_stall;

  // Only an idle controller with a free output slot takes a beat.
  assign in_stall_o = !((state_q == S_IDLE) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign emit_stall = status_i.hit && status_i.pend_valid && !status_i.out_free;

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    cmd_o         = '0;
    cmd_o.accept  = accept;
    cmd_o.chk_idx = cur_q;
    cmd_o.out_sel = OUT_NONE_LAST;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_WRITE: begin
              cmd_o.mem_wr   = 1'b1;
              cmd_o.out_load = 1'b1;
            end
            OP_READ: begin
              cmd_o.rd_cpu = 1'b1;
              state_d      = S_READ;
            end
            OP_SCAN: begin
              if (status_i.scan_en) begin
                cmd_o.scan_start = 1'b1;
                cmd_o.rd_entry   = 1'b1;
                cmd_o.rd_idx     = '0;
                cur_d            = '0;
                state_d          = S_SCAN;
              end else begin
                cmd_o.out_load = 1'b1;
              end
            end
            default: cmd_o.out_load = 1'b1;
          endcase
        end
      end
      S_READ: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_CPU_READ;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        // A new match pushes the previous one out as a non-final beat.
        if (!emit_stall) begin
          if (status_i.hit) begin
            cmd_o.pend_take = 1'b1;
            if (status_i.pend_valid) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = OUT_PEND_MID;
            end
          end
          if (status_i.last_hit || (cur_q == IDX_W'(NUM_ENTRIES - 1))) begin
            state_d = S_FLUSH;
          end else begin
            cur_d          = cur_q + IDX_W'(1);
            cmd_o.rd_entry = 1'b1;
            cmd_o.rd_idx   = cur_q + IDX_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = status_i.pend_valid ? OUT_PEND_LAST : OUT_NONE_LAST;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
    end
  end

endmodule

FILE: src/sprite_line_search_core.sv
// Sprite line search: 160-byte sprite attribute store with gated CPU access
// and a per-scanline search for up to ten sprites.
//
// Usage: input beats arrive on in_valid_i/in_stall_o with in_data_i, and
// result beats leave on out_valid_o/out_stall_i with out_data_o. A beat moves
// on a rising edge where valid is high and stall is low. Configuration bits
// are written through cfg_we_i/cfg_index_i/cfg_data_i only while the block is
// idle, a rule for the user that the block does not enforce. A CPU write
// gives one result beat in the cycle after it is taken; a CPU read passes the
// registered store read, then the output register. A scan checks one entry per
// cycle, forty for the full store, pausing while a match waits on a stalled
// output; two read ports give an entry's Y and X bytes. Matches leave as beats
// with found set, the final one with last set; a scan with no match, or with
// the display or sprites off, gives one beat with found clear.
// Reset clears the store contents (per-byte written flags), the configuration
// bits and all control state. While the receiver stalls, the held result
// stays in the output register and the walk pauses where a match must go out.
// Depends on sls_pkg, sls_ctrl and sls_datapath.
module sprite_line_search_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sls_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sls_pkg::out_item_t out_data_o
);
  import sls_pkg::*;

  sls_cmd_t    cmd;
  sls_status_t status;

  // Sequencer.
  sls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_data_i.op),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Store, compare and output register.
  sls_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A store write happens only on an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_wr |-> (in_valid_i && !in_stall_o))
    else $error("store write without an accepted beat");

  // A new result never overwrites a beat the receiver is still holding off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("output register overwritten while stalled");

  // A reported sprite sits on an entry boundary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> (out_data_o.sprite_offset[1:0] == 2'b00))
    else $error("sprite offset not on an entry boundary");

endmodule
